// ===== src/sspp_pkg.sv =====
package sspp_pkg;

   // Byte values of the status packet
   localparam logic [7:0] HDR_BYTE   = 8'hFF;
   localparam logic [7:0] STATUS_LEN = 8'd4;
   localparam logic [7:0] NO_ERROR   = 8'd0;

   // Body byte positions after the two header bytes
   localparam int unsigned BODY_CNT_W = 3;
   localparam logic [BODY_CNT_W-1:0] BODY_ID       = 3'd0;
   localparam logic [BODY_CNT_W-1:0] BODY_LENGTH   = 3'd1;
   localparam logic [BODY_CNT_W-1:0] BODY_ERROR    = 3'd2;
   localparam logic [BODY_CNT_W-1:0] BODY_POS_LOW  = 3'd3;
   localparam logic [BODY_CNT_W-1:0] BODY_POS_HIGH = 3'd4;
   localparam logic [BODY_CNT_W-1:0] BODY_CHECKSUM = 3'd5;

   // Stream widths
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 40;

   // Register port
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_EXPECTED_ID = 1'b0;
   localparam logic [7:0] EXPECTED_ID_RESET = 8'd1;

endpackage

// ===== src/servo_status_packet_parser.sv =====
// Servo status packet parser.
//
// req_* carries received serial bytes, one item per byte. The block hunts
// for two consecutive 0xFF header bytes, then collects id, length, error,
// position low, position high and checksum. When the checksum byte is
// accepted, one item goes out on rsp_* with the position, id, error byte
// and two flags: frame_ok (id matches expected_id, length 4, error 0) and
// checksum_ok (checksum equals the inverted low byte of the body sum).
// Bad packets are still reported, only with their flags cleared.
//
// Throughput is one byte per cycle. The result is registered and shows on
// rsp_tvalid the cycle after the checksum byte is accepted. If the
// receiver stalls, the result is held and req_tready drops until it is
// taken, since the single output register is the only place for it.
//
// csr_* is an APB-style port with one register, expected_id at address 0.
// Reset clears the parser to hunting, empties the output register and sets
// expected_id to 1.
module servo_status_packet_parser (
   input  logic                            clock,
   input  logic                            reset,
   // slave stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sspp_pkg::REQ_DATA_W-1:0] req_tdata,   // [7:0] rx_byte
   // master stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [15:0] position, [23:16] servo_id, [31:24] error_bits,
   // [32] frame_ok, [33] checksum_ok, [39:34] zero
   output logic [sspp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sspp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sspp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sspp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import sspp_pkg::*;

   // parser control state
   logic                  collecting_ff, collecting_in;
   logic                  last_was_ff_ff, last_was_ff_in;
   logic [BODY_CNT_W-1:0] body_count_ff, body_count_in;

   // held packet bytes
   logic [7:0] held_id_ff, held_id_in;
   logic [7:0] held_length_ff, held_length_in;
   logic [7:0] held_error_ff, held_error_in;
   logic [7:0] held_pos_low_ff, held_pos_low_in;
   logic [7:0] held_pos_high_ff, held_pos_high_in;
   logic [7:0] running_sum_ff, running_sum_in;

   // output register
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   // configuration
   logic [7:0] expected_id_ff, expected_id_in;

   logic       req_fire;
   logic       rsp_load;
   logic [7:0] rx_byte;
   logic       frame_ok;
   logic       checksum_ok;

   // Accept a byte whenever the output register is empty or being drained.
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign rx_byte    = req_tdata[7:0];

   assign frame_ok    = (held_id_ff == expected_id_ff) && (held_length_ff == STATUS_LEN) &&
                        (held_error_ff == NO_ERROR);
   assign checksum_ok = (~running_sum_ff == rx_byte);

   always_comb begin
      collecting_in    = collecting_ff;
      last_was_ff_in   = last_was_ff_ff;
      body_count_in    = body_count_ff;
      held_id_in       = held_id_ff;
      held_length_in   = held_length_ff;
      held_error_in    = held_error_ff;
      held_pos_low_in  = held_pos_low_ff;
      held_pos_high_in = held_pos_high_ff;
      running_sum_in   = running_sum_ff;
      rsp_load         = 1'b0;

      if (req_fire) begin
         if (!collecting_ff) begin
            // Hunt: the second of two 0xFF bytes opens a packet.
            if (last_was_ff_ff && (rx_byte == HDR_BYTE)) begin
               collecting_in  = 1'b1;
               body_count_in  = BODY_ID;
               running_sum_in = 8'd0;
               last_was_ff_in = 1'b0;
            end else begin
               last_was_ff_in = (rx_byte == HDR_BYTE);
            end
         end else begin
            case (body_count_ff)
               BODY_ID:       held_id_in       = rx_byte;
               BODY_LENGTH:   held_length_in   = rx_byte;
               BODY_ERROR:    held_error_in    = rx_byte;
               BODY_POS_LOW:  held_pos_low_in  = rx_byte;
               BODY_POS_HIGH: held_pos_high_in = rx_byte;
               default:       ;
            endcase

            if (body_count_ff < BODY_CHECKSUM) begin
               running_sum_in = running_sum_ff + rx_byte;
               body_count_in  = body_count_ff + 1'b1;
            end else begin
               // Checksum byte: emit the result and go back to hunting.
               rsp_load       = 1'b1;
               collecting_in  = 1'b0;
               last_was_ff_in = 1'b0;
               body_count_in  = BODY_ID;
            end
         end
      end
   end

   // Load a new result, else drop the old one once taken.
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {6'd0, checksum_ok, frame_ok, held_error_ff, held_id_ff,
                          held_pos_high_ff, held_pos_low_ff};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   // Register write in the access phase; pready is tied high.
   always_comb begin
      expected_id_in = expected_id_ff;
      if (csr_psel && csr_penable && csr_pwrite &&
          (csr_paddr[CSR_ADDR_W-1:2] == CSR_EXPECTED_ID)) begin
         expected_id_in = csr_pwdata[7:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_W-1:2] == CSR_EXPECTED_ID) begin
         csr_prdata = {{(CSR_DATA_W-8){1'b0}}, expected_id_ff};
      end
   end

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff  <= 1'b0;
         last_was_ff_ff <= 1'b0;
         body_count_ff  <= BODY_ID;
         rsp_tvalid_ff  <= 1'b0;
         expected_id_ff <= EXPECTED_ID_RESET;
      end else begin
         collecting_ff  <= collecting_in;
         last_was_ff_ff <= last_was_ff_in;
         body_count_ff  <= body_count_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
         expected_id_ff <= expected_id_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      held_id_ff       <= held_id_in;
      held_length_ff   <= held_length_in;
      held_error_ff    <= held_error_in;
      held_pos_low_ff  <= held_pos_low_in;
      held_pos_high_ff <= held_pos_high_in;
      running_sum_ff   <= running_sum_in;
      rsp_tdata_ff     <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// ===== src/sspp_checker.sv =====
module sspp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sspp_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import sspp_pkg::*;

   // A stalled result holds its item.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed or dropped while stalled");

   // Input backpressure only while a result waits on a stalled receiver.
   a_req_stall: assert property (@(posedge clock)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without a stalled result");

   // A result only follows an accepted byte.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result without an accepted byte");

   // Reset empties the output register.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Padding bits above the flags stay zero.
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_DATA_W-1:34] == '0))
      else $error("rsp padding bits set");

endmodule

bind servo_status_packet_parser sspp_checker u_sspp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import sspp_pkg::*;

   // Status fields as they sit in rsp_tdata, lowest bits last
   typedef struct packed {
      logic        checksum_ok;
      logic        frame_ok;
      logic [7:0]  error_bits;
      logic [7:0]  servo_id;
      logic [15:0] position;
   } status_type;

   localparam logic [CSR_ADDR_W-1:0] CSR_ID_ADDR = {CSR_EXPECTED_ID, 2'b00};
   localparam int QUIET_LIMIT = 2000;   // cycles with no item moving on either side
   localparam int HOLD_CYCLES = 96;     // long receiver stall
   localparam int PHASE_BYTES = 270;    // random bytes per expected_id setting

   // Opening bytes: a run of three 0xFF (the third becomes the id), a clean
   // packet that matches the reset id, a packet with bad length, error and
   // checksum whose checksum byte is 0xFF, then a lone 0xFF broken by 0x00.
   localparam logic [7:0] OPENING_BYTES [26] = '{
      8'hFF, 8'hFF, 8'hFF, 8'h04, 8'h00, 8'hFF, 8'hFF, 8'hFE,
      8'hFF, 8'hFF, 8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'hFA,
      8'hFF, 8'hFF, 8'h01, 8'h05, 8'h80, 8'h12, 8'h34, 8'hFF,
      8'hFF, 8'h00
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [7:0] rx_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [15:0] position, [23:16] servo_id, [31:24] error_bits,
   // [32] frame_ok, [33] checksum_ok, [39:34] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Bytes waiting to be offered, and status items waiting to come out
   logic [7:0] rx_bytes[$];
   status_type pending_status[$];

   // Parser shadow state, starting from its declared values; reset does not touch it
   logic                  in_packet    = 1'b0;
   logic                  prev_was_hdr = 1'b0;
   logic [BODY_CNT_W-1:0] body_pos     = BODY_ID;
   logic [7:0]            pkt_id       = '0;
   logic [7:0]            pkt_len      = '0;
   logic [7:0]            pkt_err      = '0;
   logic [7:0]            pkt_pos_lo   = '0;
   logic [7:0]            pkt_pos_hi   = '0;
   logic [7:0]            body_sum     = '0;
   logic [7:0]            want_id      = EXPECTED_ID_RESET;

   // Handshake flags seen at the last rising edge
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;

   int mismatch_count = 0;
   int quiet_cycles   = 0;

   // Sender and receiver pacing
   int req_gap     = 0;
   bit req_calm    = 1'b0;
   int rsp_gap     = 0;
   bit rsp_calm    = 1'b0;
   int rsp_taken   = 0;
   int rsp_hold    = 0;

   always #4 clock = ~clock;

   servo_status_packet_parser u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Advance the shadow parser by one accepted byte; queue a status item
   // when the checksum byte closes a packet.
   function automatic void parse_rx_byte(input logic [7:0] rx);
      status_type s;
      logic [7:0] want_cks;
      if (!in_packet) begin
         // hunting: the second of two 0xFF bytes opens a packet
         if (prev_was_hdr && rx == HDR_BYTE) begin
            in_packet    = 1'b1;
            body_pos     = BODY_ID;
            body_sum     = '0;
            prev_was_hdr = 1'b0;
         end else begin
            prev_was_hdr = (rx == HDR_BYTE);
         end
      end else begin
         case (body_pos)
            BODY_ID:       pkt_id     = rx;
            BODY_LENGTH:   pkt_len    = rx;
            BODY_ERROR:    pkt_err    = rx;
            BODY_POS_LOW:  pkt_pos_lo = rx;
            BODY_POS_HIGH: pkt_pos_hi = rx;
            default: ;
         endcase
         if (body_pos != BODY_CHECKSUM) begin
            body_sum = body_sum + rx;
            body_pos = body_pos + 1'b1;
         end else begin
            want_cks      = ~body_sum;
            s.position    = {pkt_pos_hi, pkt_pos_lo};
            s.servo_id    = pkt_id;
            s.error_bits  = pkt_err;
            s.frame_ok    = (pkt_id == want_id) && (pkt_len == STATUS_LEN) &&
                            (pkt_err == NO_ERROR);
            s.checksum_ok = (want_cks == rx);
            pending_status.push_back(s);
            // back to hunting; the checksum byte never counts as a header
            in_packet    = 1'b0;
            prev_was_hdr = 1'b0;
            body_pos     = BODY_ID;
         end
      end
   endfunction

   function automatic void check_value(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s differs, expected %h, actual %h", $time, what, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic int draw_gap(input bit calm);
      return calm ? 0 : $urandom_range(0, 5);
   endfunction

   // Driver: offer the next byte once the current one is taken; hold the
   // byte and tvalid steady while tready is low.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (rx_bytes.size() != 0) begin
            req_tdata  <= rx_bytes.pop_front();
            req_tvalid <= 1'b1;
            // flip between idling and back-to-back stretches now and then
            if ($urandom_range(0, 47) == 0) req_calm = ~req_calm;
            req_gap = draw_gap(req_calm);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: pause a random number of cycles after each item, and twice
   // hold off for a long stretch so the block fills and stalls its input.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_fire) begin
            rsp_taken++;
            if (rsp_taken == 20 || rsp_taken == 120) rsp_hold = HOLD_CYCLES;
            if ($urandom_range(0, 31) == 0) rsp_calm = ~rsp_calm;
            rsp_gap = draw_gap(rsp_calm);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Monitor: predict on every accepted byte, check every accepted status
   // item against the oldest prediction, and watch for a hang.
   always @(posedge clock) begin
      status_type got;
      status_type want;
      if (!reset) begin
         req_fire <= req_tvalid && req_tready;
         rsp_fire <= rsp_tvalid && rsp_tready;
         if (req_tvalid && req_tready) parse_rx_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got = status_type'(rsp_tdata[33:0]);
            if (pending_status.size() == 0) begin
               $display("%0t: status item with none expected, expected nothing, actual %h",
                        $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = pending_status.pop_front();
               check_value("position",    32'(want.position),    32'(got.position));
               check_value("servo_id",    32'(want.servo_id),    32'(got.servo_id));
               check_value("error_bits",  32'(want.error_bits),  32'(got.error_bits));
               check_value("frame_ok",    32'(want.frame_ok),    32'(got.frame_ok));
               check_value("checksum_ok", 32'(want.checksum_ok), 32'(got.checksum_ok));
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
            $display("Mismatches found");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Wait until every byte is taken and every status item has come out,
   // then let the pipeline settle.
   task automatic drain();
      while (rx_bytes.size() != 0 || req_tvalid) @(posedge clock);
      while (pending_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [7:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ID_ADDR;
      csr_pwdata  <= {{(CSR_DATA_W-8){1'b0}}, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      want_id = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_read_check(input logic [7:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ID_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      check_value("expected_id readback", {{(CSR_DATA_W-8){1'b0}}, value}, csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Queue mostly well-formed packets with random content, mixed with
   // noise: stray bytes, 0xFF runs and headers broken after one 0xFF.
   task automatic feed_random(input int count);
      int         queued;
      int         n;
      logic [7:0] body[5];
      logic [7:0] sum;
      logic [7:0] cks;
      queued = 0;
      while (queued < count) begin
         if ($urandom_range(0, 4) != 0) begin
            body[0] = ($urandom_range(0, 3) != 0) ? want_id    : 8'($urandom);
            body[1] = ($urandom_range(0, 4) != 0) ? STATUS_LEN : 8'($urandom);
            body[2] = ($urandom_range(0, 4) != 0) ? NO_ERROR   : 8'($urandom);
            body[3] = 8'($urandom);
            body[4] = 8'($urandom);
            sum = '0;
            rx_bytes.push_back(HDR_BYTE);
            rx_bytes.push_back(HDR_BYTE);
            foreach (body[i]) begin
               rx_bytes.push_back(body[i]);
               sum = sum + body[i];
            end
            cks = ~sum;
            // corrupt the checksum now and then
            if ($urandom_range(0, 5) == 0) cks = cks ^ 8'($urandom_range(1, 255));
            rx_bytes.push_back(cks);
            queued += 8;
         end else begin
            n = $urandom_range(1, 3);
            repeat (n) rx_bytes.push_back($urandom_range(0, 1) ? HDR_BYTE : 8'($urandom));
            queued += n;
         end
      end
   endtask

   initial begin
      logic [7:0] id_plan[6];

      // hold reset, then drop it at a falling edge
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_read_check(EXPECTED_ID_RESET);

      foreach (OPENING_BYTES[i]) rx_bytes.push_back(OPENING_BYTES[i]);
      drain();

      // walk expected_id through its extremes, 255, random values and back
      id_plan = '{8'd0, 8'd254, 8'd255, 8'($urandom_range(0, 254)),
                  8'($urandom_range(0, 254)), EXPECTED_ID_RESET};
      foreach (id_plan[i]) begin
         csr_write(id_plan[i]);
         csr_read_check(id_plan[i]);
         feed_random(PHASE_BYTES);
         drain();
      end

      if (pending_status.size() != 0) begin
         $display("%0t: %0d status items never arrived, expected 0, actual %0d",
                  $time, pending_status.size(), pending_status.size());
         mismatch_count++;
      end

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
